### design/tilt_fusion_pid_motor_drive_assert.svh
// ----------------------------------------------------------------------------
// tilt fusion pid motor drive assertion macros
// shorthand for clocked assertions on clk_i with an active-low reset
// ----------------------------------------------------------------------------
`ifndef TILT_FUSION_PID_MOTOR_DRIVE_ASSERT_SVH
`define TILT_FUSION_PID_MOTOR_DRIVE_ASSERT_SVH

// antecedent at one edge implies consequent at the next edge
`define TFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition holds at every edge out of reset
`define TFPM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

### design/tfpm_pkg.sv
// ----------------------------------------------------------------------------
// tfpm_pkg
// constants, register indexes and the cordic angle table
// ----------------------------------------------------------------------------
`default_nettype none

package tfpm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CIDX_W       = $clog2(TABLE_LEN);
  localparam int DIV_NUM_W    = 17;

  localparam logic [7:0] RATE_DIVISOR  = 8'd131;
  localparam logic [7:0] DRIVE_DIVISOR = 8'd90;

  // reciprocal constants, exact for any 17-bit numerator
  localparam int RECIP_W     = 22;
  localparam int RATE_SHIFT  = 25;
  localparam int DRIVE_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RATE_RECIP = RECIP_W'(
    ((64'd1 << RATE_SHIFT) + 64'(RATE_DIVISOR) - 64'd1) / 64'(RATE_DIVISOR));
  localparam logic [RECIP_W-1:0] DRIVE_RECIP = RECIP_W'(
    ((64'd1 << DRIVE_SHIFT) + 64'(DRIVE_DIVISOR) - 64'd1) / 64'(DRIVE_DIVISOR));

  localparam logic signed [15:0] DEG90_Q8  = 16'sd23040;
  localparam logic signed [17:0] DEG180_Q8 = 18'sd46080;
  // 90 degrees at 2^-32 degree resolution
  localparam logic signed [53:0] DRIVE_LIM = 54'sd386547056640;

  localparam logic [2:0] CFG_KP     = 3'd0;
  localparam logic [2:0] CFG_KI     = 3'd1;
  localparam logic [2:0] CFG_KD     = 3'd2;
  localparam logic [2:0] CFG_TARGET = 3'd3;
  localparam logic [2:0] CFG_WEIGHT = 3'd4;
  localparam logic [2:0] CFG_PERIOD = 3'd5;
  localparam logic [2:0] CFG_BIAS   = 3'd6;
  localparam logic [2:0] CFG_OFFSET = 3'd7;

  // atan(2^-i) in degrees, Q16
  function automatic logic [22:0] atan_deg_q16(input logic [CIDX_W-1:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/tfpm_cordic.sv
// ----------------------------------------------------------------------------
// tfpm_cordic
// iterative vectoring cordic, atan(y/z) in degrees Q8.8
// ----------------------------------------------------------------------------
`default_nettype none

module tfpm_cordic import tfpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] z_i,
  output logic               done_o,
  output logic signed [15:0] angle_o
);

  logic signed [33:0] x_q, y_q;
  logic signed [25:0] ang_q;
  logic [CIDX_W-1:0]  cnt_q;
  logic               busy_q, done_q;

  logic signed [33:0] z_ext, y_ext, xs, ys;
  logic signed [25:0] at, ang_rnd;

  always_comb begin
    z_ext = 34'(z_i);
    y_ext = 34'(y_i);
    xs    = x_q >>> cnt_q;
    ys    = y_q >>> cnt_q;
    at    = signed'({3'b000, atan_deg_q16(cnt_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ang_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= '0;
      if (z_i == 16'sd0) begin
        // vertical vector: pre-scaled so rounding gives exactly +-90
        busy_q <= 1'b0;
        done_q <= 1'b1;
        if (y_i > 16'sd0)      ang_q <= 26'(DEG90_Q8) <<< 8;
        else if (y_i < 16'sd0) ang_q <= -(26'(DEG90_Q8) <<< 8);
        else                   ang_q <= '0;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        ang_q  <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[33]) ang_q <= ang_q + at;
      else          ang_q <= ang_q - at;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CIDX_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // fold into the right half plane
      x_q <= (z_i < 16'sd0 ? -z_ext : z_ext) <<< 14;
      y_q <= (z_i < 16'sd0 ? -y_ext : y_ext) <<< 14;
    end else if (busy_q) begin
      if (!y_q[33]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
      end
    end
  end

  always_comb begin
    ang_rnd = (ang_q + 26'sd128) >>> 8;
    if (ang_rnd > 26'(DEG90_Q8))       angle_o = DEG90_Q8;
    else if (ang_rnd < -26'(DEG90_Q8)) angle_o = -DEG90_Q8;
    else                               angle_o = ang_rnd[15:0];
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

### design/tfpm_div.sv
// ----------------------------------------------------------------------------
// tfpm_div
// constant divider by reciprocal multiplication; the numerator is registered at start, the quotient with done
// ----------------------------------------------------------------------------
`default_nettype none

module tfpm_div import tfpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic                 drive_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic [DIV_NUM_W-1:0] num_q, quo_q;
  logic                 drive_q, busy_q, done_q;

  logic [RECIP_W-1:0]           recip;
  logic [DIV_NUM_W+RECIP_W-1:0] prod;

  always_comb begin
    recip = drive_q ? DRIVE_RECIP : RATE_RECIP;
    prod  = (DIV_NUM_W+RECIP_W)'(num_q) * (DIV_NUM_W+RECIP_W)'(recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q   <= num_i;
      drive_q <= drive_i;
    end else if (busy_q) begin
      if (drive_q) quo_q <= DIV_NUM_W'(prod >> DRIVE_SHIFT);
      else         quo_q <= DIV_NUM_W'(prod >> RATE_SHIFT);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### design/tilt_fusion_pid_motor_drive.sv
// sequence: an input transaction starts the 16-step cordic loop with the rate
//   divide overlapping it, then come the multiply steps, the drive scaling
//   divide and the load of the output register
// flow: one transaction at a time, the next waits longer while a result waits
// reset: gains, target, weight, period, bias and offset take their defaults,
//   fused state and pid history clear, the next tick seeds from the accel
`default_nettype none

`include "tilt_fusion_pid_motor_drive_assert.svh"

// ----------------------------------------------------------------------------
// tilt_fusion_pid_motor_drive
// accel/gyro complementary tilt filter with pid motor drive and pwm mapping
// ----------------------------------------------------------------------------
module tilt_fusion_pid_motor_drive import tfpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         pwm_duty_o,
  output logic               reverse_o,
  output logic signed [16:0] fused_tilt_o,
  output logic signed [15:0] accel_tilt_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RATE = 4'd1;
  localparam logic [3:0] ST_STEP = 4'd2;
  localparam logic [3:0] ST_F1   = 4'd3;
  localparam logic [3:0] ST_F2   = 4'd4;
  localparam logic [3:0] ST_E    = 4'd5;
  localparam logic [3:0] ST_I    = 4'd6;
  localparam logic [3:0] ST_P    = 4'd7;
  localparam logic [3:0] ST_II   = 4'd8;
  localparam logic [3:0] ST_D1   = 4'd9;
  localparam logic [3:0] ST_D2   = 4'd10;
  localparam logic [3:0] ST_U    = 4'd11;
  localparam logic [3:0] ST_M    = 4'd12;
  localparam logic [3:0] ST_DV   = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  // configuration
  logic [15:0]        kp_q, ki_q, kd_q, weight_q, period_q;
  logic signed [15:0] target_q, bias_q;
  logic [7:0]         offset_q;

  // filter and pid state
  logic signed [16:0] tilt_q;
  logic signed [15:0] ei_q;
  logic signed [17:0] last_q;
  logic               first_q;

  // sequencer and working registers
  logic [3:0]         state_q;
  logic               rate_neg_q;
  logic signed [51:0] prod_q;
  logic signed [37:0] sum_q;
  logic signed [16:0] fused_q;
  logic signed [17:0] e_q;
  logic signed [19:0] isum_q;
  logic signed [53:0] acc_q;
  logic               zero_q, rev_q;

  // output register
  logic               out_valid_q;
  logic [7:0]         pwm_q;
  logic               rev_out_q;
  logic signed [16:0] fused_out_q;
  logic signed [15:0] accel_out_q;

  logic               accept, load_out;
  logic signed [16:0] gsum;
  logic [16:0]        gmag;
  logic               cordic_done, div_done, div_start;
  logic signed [15:0] acc_tilt;
  logic [16:0]        div_num, div_quo;
  logic               div_drive;

  logic signed [39:0] mul_a, q40;
  logic signed [17:0] mul_b;
  logic signed [57:0] mul_p;
  logic signed [51:0] step_rnd, isum_rnd;
  logic signed [17:0] step;
  logic signed [37:0] fsum, fsum_rnd;
  logic signed [16:0] fused;
  logic signed [53:0] u;
  logic signed [39:0] mag;
  logic signed [15:0] ei_next;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign load_out   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    gsum = 17'(gyro_x_i) + 17'(bias_q);
    gmag = gsum[16] ? 17'(-gsum) : 17'(gsum);
  end

  tfpm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .y_i     (accel_y_i),
    .z_i     (accel_z_i),
    .done_o  (cordic_done),
    .angle_o (acc_tilt)
  );

  assign div_start = accept || (state_q == ST_M);
  assign div_num   = (state_q == ST_M) ? 17'(prod_q[48:32]) : gmag;
  assign div_drive = (state_q == ST_M);

  tfpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .drive_i (div_drive),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // datapath helpers
  always_comb begin
    q40      = signed'({23'b0, div_quo});
    step_rnd = (prod_q + 52'sd128) >>> 8;
    step     = first_q ? 18'(acc_tilt) : step_rnd[17:0];
    fsum     = sum_q + prod_q[37:0];
    fsum_rnd = (fsum + 38'sd32768) >>> 16;
    if (fsum_rnd > 38'(DEG180_Q8))       fused = 17'(DEG180_Q8);
    else if (fsum_rnd < -38'(DEG180_Q8)) fused = 17'(-DEG180_Q8);
    else                                 fused = fsum_rnd[16:0];
    isum_rnd = (prod_q + 52'sd32768) >>> 16;
    if (acc_q > DRIVE_LIM)       u = DRIVE_LIM;
    else if (acc_q < -DRIVE_LIM) u = -DRIVE_LIM;
    else                         u = acc_q;
    mag = u[53] ? 40'(-u) : 40'(u);
    if (isum_q > 20'(DEG90_Q8))       ei_next = DEG90_Q8;
    else if (isum_q < -20'(DEG90_Q8)) ei_next = -DEG90_Q8;
    else                              ei_next = isum_q[15:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_RATE: begin
        mul_a = rate_neg_q ? -q40 : q40;
        mul_b = signed'({2'b00, period_q});
      end
      ST_STEP: begin
        mul_a = 40'(tilt_q) + 40'(step);
        mul_b = signed'({2'b00, weight_q});
      end
      ST_F1: begin
        mul_a = 40'(acc_tilt);
        mul_b = 18'sd65536 - signed'({2'b00, weight_q});
      end
      ST_E: begin
        mul_a = 40'(target_q) - 40'(fused_q);
        mul_b = signed'({2'b00, period_q});
      end
      ST_I: begin
        mul_a = 40'(e_q);
        mul_b = signed'({2'b00, kp_q});
      end
      ST_P: begin
        mul_a = 40'(isum_q);
        mul_b = signed'({2'b00, ki_q});
      end
      ST_II: begin
        mul_a = 40'(e_q) - 40'(last_q);
        mul_b = signed'({2'b00, period_q});
      end
      ST_D1: begin
        mul_a = prod_q[39:0];
        mul_b = signed'({2'b00, kd_q});
      end
      ST_U: begin
        mul_a = mag;
        mul_b = signed'({10'b0, 8'(8'd255 - offset_q)});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= 16'd1792;
      ki_q     <= 16'd4608;
      kd_q     <= 16'd0;
      target_q <= 16'sd0;
      weight_q <= 16'd64225;
      period_q <= 16'd252;
      bias_q   <= 16'sd866;
      offset_q <= 8'd152;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KP:     kp_q     <= cfg_data_i;
        CFG_KI:     ki_q     <= cfg_data_i;
        CFG_KD:     kd_q     <= cfg_data_i;
        CFG_TARGET: target_q <= signed'(cfg_data_i);
        CFG_WEIGHT: weight_q <= cfg_data_i;
        CFG_PERIOD: period_q <= cfg_data_i;
        CFG_BIAS:   bias_q   <= signed'(cfg_data_i);
        CFG_OFFSET: offset_q <= cfg_data_i[7:0];
        default:    ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tilt_q      <= '0;
      ei_q        <= '0;
      last_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (accept) state_q <= ST_RATE;
        ST_RATE: if (cordic_done && div_done) state_q <= ST_STEP;
        ST_STEP: state_q <= ST_F1;
        ST_F1:   state_q <= ST_F2;
        ST_F2:   state_q <= ST_E;
        ST_E:    state_q <= ST_I;
        ST_I:    state_q <= ST_P;
        ST_P:    state_q <= ST_II;
        ST_II:   state_q <= ST_D1;
        ST_D1:   state_q <= ST_D2;
        ST_D2:   state_q <= ST_U;
        ST_U: begin
          ei_q    <= ei_next;
          last_q  <= e_q;
          tilt_q  <= fused_q;
          first_q <= 1'b0;
          state_q <= ST_M;
        end
        ST_M:    state_q <= ST_DV;
        ST_DV:   if (div_done) state_q <= ST_OUT;
        ST_OUT:  if (load_out) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[51:0];
    if (accept) rate_neg_q <= gsum[16];
    case (state_q)
      ST_F1: sum_q   <= prod_q[37:0];
      ST_F2: fused_q <= fused;
      ST_E:  e_q     <= 18'(target_q) - 18'(fused_q);
      ST_I:  isum_q  <= 20'(ei_q) + isum_rnd[19:0];
      ST_P:  acc_q   <= 54'(prod_q) <<< 16;
      ST_II: acc_q   <= acc_q + (54'(prod_q) <<< 16);
      ST_D2: acc_q   <= acc_q + 54'(prod_q);
      ST_U: begin
        zero_q <= (u == 54'sd0);
        rev_q  <= u[53];
      end
      default: ;
    endcase
    if (load_out) begin
      pwm_q       <= zero_q ? 8'd0 : div_quo[7:0] + offset_q;
      rev_out_q   <= rev_q;
      fused_out_q <= fused_q;
      accel_out_q <= acc_tilt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pwm_duty_o   = pwm_q;
  assign reverse_o    = rev_out_q;
  assign fused_tilt_o = fused_out_q;
  assign accel_tilt_o = accel_out_q;

  `TFPM_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "ready high after a transaction")
  `TFPM_ASSERT_NEXT(a_result_loaded, load_out, out_valid_o && in_ready_o, "result not presented")
  `TFPM_ASSERT_ALWAYS(a_integral_bound, (ei_q <= DEG90_Q8) && (ei_q >= -DEG90_Q8), "integral out of range")

endmodule

`default_nettype wire

### tb/sv/tb_tilt_fusion_pid_motor_drive.sv
// ----------------------------------------------------------------------------
// tb_tilt_fusion_pid_motor_drive
// drives sample ticks with bursty valid and a stalling receiver, predicts each
// result with a local fixed-point model of the filter and pid, checks per field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_tilt_fusion_pid_motor_drive;
  import tfpm_pkg::*;

  typedef struct packed {
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
  } tick_t;

  typedef struct packed {
    logic [7:0]         duty;
    logic               rev;
    logic signed [16:0] fused;
    logic signed [15:0] acc;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = CFG_KP;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] accel_y_i = '0, accel_z_i = '0, gyro_x_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] pwm_duty_o;
  logic reverse_o;
  logic signed [16:0] fused_tilt_o;
  logic signed [15:0] accel_tilt_o;

  tilt_fusion_pid_motor_drive dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  longint kp, ki, kd, tgt, wgt, per, bias, offs;
  longint est, integ, last_err;
  bit seed_tick;

  tick_t  pending_ticks[$];
  drive_t expected_drives[$];
  int     errors = 0;
  longint cycles = 0;
  int     burst_left = 0, gap_left = 0;
  int     stall_phase = 0, stall_mode = 0;

  localparam longint ATAN_Q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint tilt_from_accel(longint y, longint z);
    longint x, yy, ang, xs, ys;
    ang = 0;
    if (z == 0) return y > 0 ? 23040 : (y < 0 ? -23040 : 0);
    x  = (z < 0 ? -z : z) * 16384;
    yy = (z < 0 ? -y : y) * 16384;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = sra(x, i);
      ys = sra(yy, i);
      if (yy >= 0) begin
        x += ys; yy -= xs; ang += ATAN_Q16[i];
      end else begin
        x -= ys; yy += xs; ang -= ATAN_Q16[i];
      end
    end
    return clip(rnd_shift(ang, 8), -23040, 23040);
  endfunction

  function automatic drive_t predict_drive(tick_t t);
    drive_t r;
    longint acc, rate, stp, fused, e, isum, u, lim, mag, duty;
    lim  = longint'(90) << 32;
    acc  = tilt_from_accel(t.ay, t.az);
    rate = (longint'(t.gx) + bias) / 131;  // truncates toward zero
    stp  = rnd_shift(rate * per, 8);
    if (seed_tick) stp = acc;
    fused = rnd_shift(wgt * (est + stp) + (65536 - wgt) * acc, 16);
    fused = clip(fused, -46080, 46080);
    e    = tgt - fused;
    isum = integ + rnd_shift(e * per, 16);
    u = e * kp * 65536 + isum * ki * 65536 + (e - last_err) * per * kd;
    u = clip(u, -lim, lim);
    integ = clip(isum, -23040, 23040);
    last_err = e;
    est = fused;
    seed_tick = 1'b0;
    duty = 0;
    r.rev = 1'b0;
    if (u != 0) begin
      r.rev = u < 0;
      mag = u < 0 ? -u : u;
      duty = mag * (255 - offs) / lim + offs;
    end
    r.duty  = duty[7:0];
    r.fused = fused[16:0];
    r.acc   = acc[15:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_drives.push_back(predict_drive({accel_y_i, accel_z_i, gyro_x_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          accel_y_i <= t.ay;
          accel_z_i <= t.az;
          gyro_x_i <= t.gx;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes every so often
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_drives.size() == 0) begin
          report("unexpected result, duty", pwm_duty_o, 0);
        end else begin
          drive_t w;
          w = expected_drives.pop_front();
          if (pwm_duty_o !== w.duty) report("pwm_duty", pwm_duty_o, w.duty);
          if (reverse_o !== w.rev) report("reverse", reverse_o, w.rev);
          if (fused_tilt_o !== w.fused) report("fused_tilt", fused_tilt_o, w.fused);
          if (accel_tilt_o !== w.acc) report("accel_tilt", accel_tilt_o, w.acc);
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= (stall_phase % 7) < 3;
        default: out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 64'd3000000) begin
      $display("tilt_fusion_pid_motor_drive: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KP:     kp = val;
      CFG_KI:     ki = val;
      CFG_KD:     kd = val;
      CFG_TARGET: tgt = longint'(signed'(val));
      CFG_WEIGHT: wgt = val;
      CFG_PERIOD: per = val;
      CFG_BIAS:   bias = longint'(signed'(val));
      default:    offs = val[7:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_ticks.size() == 0 && !in_valid_i && expected_drives.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic tick_t rand_tick(bit tame);
    tick_t t;
    t.ay = 16'($urandom);
    t.az = 16'($urandom);
    t.gx = 16'($urandom);
    if (tame) begin
      t.ay = 16'($signed($urandom_range(0, 16000)) - 8000);
      t.az = 16'($signed($urandom_range(0, 8000)) + 12000);
      t.gx = 16'($signed($urandom_range(0, 6000)) - 3000);
      if ($urandom_range(0, 7) == 0) t.az = 0;
    end
    return t;
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pending_ticks.push_back(rand_tick($urandom_range(0, 3) != 0));
  endtask

  initial begin
    kp = 1792; ki = 4608; kd = 0; tgt = 0; wgt = 64225; per = 252; bias = 866; offs = 152;
    est = 0; integ = 0; last_err = 0; seed_tick = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, zero z, both zero, saturated inputs
    pending_ticks.push_back('{16'sd0, 16'sd0, 16'sd0});
    pending_ticks.push_back('{16'sd1000, 16'sd0, 16'sd0});
    pending_ticks.push_back('{-16'sd1000, 16'sd0, 16'sd0});
    pending_ticks.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_ticks.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
    pending_ticks.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff});
    pending_ticks.push_back('{16'sh8000, 16'sh7fff, 16'sh8000});
    pending_ticks.push_back('{16'sd0, 16'sd16384, -16'sd866});
    pending_ticks.push_back('{16'sd16384, 16'sd16384, 16'sd100});
    pending_ticks.push_back('{16'sd0, -16'sd16384, -16'sd1});
    pending_ticks.push_back('{16'sd1, 16'sh8000, 16'sd0});
    pending_ticks.push_back('{16'sd0, 16'sd0, 16'sh8000});
    drain();

    // gains and target extremes, zero drive case with all gains zero
    write_reg(CFG_KP, 16'd0);
    write_reg(CFG_KI, 16'd0);
    write_reg(CFG_KD, 16'd0);
    pending_ticks.push_back('{16'sd500, 16'sd16000, 16'sd0});
    pending_ticks.push_back('{16'sd0, 16'sd0, 16'sd0});
    add_random(150);
    drain();

    write_reg(CFG_KP, 16'hffff);
    write_reg(CFG_KI, 16'hffff);
    write_reg(CFG_KD, 16'hffff);
    write_reg(CFG_TARGET, 16'sh8000);
    write_reg(CFG_WEIGHT, 16'hffff);
    write_reg(CFG_PERIOD, 16'hffff);
    write_reg(CFG_BIAS, 16'sh7fff);
    write_reg(CFG_OFFSET, 16'd255);
    add_random(200);
    drain();

    // zero period and zero weight
    write_reg(CFG_PERIOD, 16'd0);
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_TARGET, 16'sh7fff);
    write_reg(CFG_BIAS, 16'sh8000);
    write_reg(CFG_OFFSET, 16'd0);
    write_reg(CFG_KD, 16'd300);
    add_random(150);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_KP, 16'($urandom_range(0, 4000)));
      write_reg(CFG_KI, 16'($urandom_range(0, 8000)));
      write_reg(CFG_KD, 16'($urandom));
      write_reg(CFG_TARGET, 16'($signed($urandom_range(0, 46080)) - 23040));
      write_reg(CFG_WEIGHT, 16'($urandom_range(60000, 65535)));
      write_reg(CFG_PERIOD, 16'($urandom_range(1, 2000)));
      write_reg(CFG_BIAS, 16'($urandom));
      write_reg(CFG_OFFSET, 16'($urandom_range(0, 255)));
      add_random(150);
      drain();
    end

    if (errors == 0) begin
      $display("tilt_fusion_pid_motor_drive: match");
    end else begin
      $display("tilt_fusion_pid_motor_drive: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
